// File: rtl/core/pwmenc_pkg.sv
// Package for the PWM encoder decoder with multiturn counter.
// Holds widths, register indexes and the controller/datapath command types.
// No dependencies.
package pwmenc_pkg;

  localparam int TIMER_BITS    = 16;
  localparam int TURN_BITS     = 20;
  localparam int ERROR_BITS    = 8;
  localparam int ANGLE_BITS    = 12;
  localparam int CLK_BITS      = 13;
  localparam int POS_BITS      = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;

  // Scaled high time before the division: high_ticks * cycle_clocks.
  localparam int PROD_BITS = TIMER_BITS + CLK_BITS;
  localparam int CNT_BITS  = $clog2(PROD_BITS);

  localparam logic [CFG_IDX_BITS-1:0] REG_CYCLE_CLOCKS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_VALID    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_VALID    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_HIGH    = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_LOW     = CFG_IDX_BITS'(4);

  localparam logic [CLK_BITS-1:0]   RST_CYCLE_CLOCKS = CLK_BITS'(4119);
  localparam logic [CLK_BITS-1:0]   RST_MIN_VALID    = CLK_BITS'(16);
  localparam logic [CLK_BITS-1:0]   RST_MAX_VALID    = CLK_BITS'(4111);
  localparam logic [ANGLE_BITS-1:0] RST_WRAP_HIGH    = ANGLE_BITS'(3000);
  localparam logic [ANGLE_BITS-1:0] RST_WRAP_LOW     = ANGLE_BITS'(1000);

  typedef struct packed {
    logic load;    // capture the input word
    logic mul;     // form the product and set up the divider
    logic step;    // one divider iteration
    logic update;  // commit angle, turns and error count
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;  // the current iteration is the final one
  } dp_sts_t;

endpackage

// File: rtl/core/pwmenc_if.sv
// Channel interfaces for the PWM encoder decoder: input, result and configuration.
// Depends on pwmenc_pkg for field widths.
interface pwmenc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pwmenc_pkg::TIMER_BITS-1:0]    period_ticks;
  logic [pwmenc_pkg::TIMER_BITS-1:0]    high_ticks;

  modport source (output valid, period_ticks, high_ticks, input ready);
  modport sink (input valid, period_ticks, high_ticks, output ready);
endinterface

interface pwmenc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 reading_valid;
  logic [pwmenc_pkg::ANGLE_BITS-1:0]    single_turn;
  logic signed [pwmenc_pkg::TURN_BITS-1:0] turn_count;
  logic [pwmenc_pkg::POS_BITS-1:0]      position;
  logic [pwmenc_pkg::ERROR_BITS-1:0]    error_count;

  modport source (output valid, reading_valid, single_turn, turn_count, position,
                  error_count, input ready);
  modport sink (input valid, reading_valid, single_turn, turn_count, position,
                error_count, output ready);
endinterface

interface pwmenc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [pwmenc_pkg::CFG_IDX_BITS-1:0]   index;
  logic [pwmenc_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/pwm_encoder_multiturn_decoder.sv
// Each input word occupies the block until its result is committed, and no new word
// is accepted before then. The word is captured in the idle state, then comes the
// high_ticks * cycle_clocks multiply, then 29 iterations of the radix-2 divider by
// period_ticks (one quotient bit per cycle over the 29-bit product), and last the
// update of the angle, turn counter and error count. The result is presented from
// the next cycle on. The result register is separate from the input side, so a new
// word is accepted while the previous result waits to be taken; its update then
// waits until that result is taken.
// Configuration writes are always taken; write them only while the block is idle.
module pwm_encoder_multiturn_decoder (
  input logic          clk,
  input logic          rst_n,
  pwmenc_in_if.sink    in_ch,
  pwmenc_out_if.source out_ch,
  pwmenc_cfg_if.sink   cfg_ch
);

  pwmenc_pkg::ctrl_cmd_t cmd;
  pwmenc_pkg::dp_sts_t   sts;

  assign cfg_ch.ready = 1'b1;

  pwmenc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pwmenc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .period_ticks  (in_ch.period_ticks),
    .high_ticks    (in_ch.high_ticks),
    .reading_valid (out_ch.reading_valid),
    .single_turn   (out_ch.single_turn),
    .turn_count    (out_ch.turn_count),
    .position      (out_ch.position),
    .error_count   (out_ch.error_count)
  );

endmodule

// File: rtl/core/pwmenc_ctrl.sv
// Controller for the PWM encoder decoder: sequences multiply, divide and update.
// Depends on pwmenc_pkg for the command and status types.
module pwmenc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  pwmenc_pkg::dp_sts_t    sts,
  output pwmenc_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  // The result register may be refilled in the cycle its word is taken.
  assign out_free  = !out_vld_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r && !out_ready;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          cmd.update  = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// File: rtl/core/pwmenc_dp.sv
// Datapath for the PWM encoder decoder: configuration registers, multiplier,
// radix-2 restoring divider and the angle, turn and error state. Uses pwmenc_pkg.
module pwmenc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pwmenc_pkg::ctrl_cmd_t                 cmd,
  output pwmenc_pkg::dp_sts_t                   sts,
  input  logic                                  cfg_we,
  input  logic [pwmenc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pwmenc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [pwmenc_pkg::TIMER_BITS-1:0]     period_ticks,
  input  logic [pwmenc_pkg::TIMER_BITS-1:0]     high_ticks,
  output logic                                  reading_valid,
  output logic [pwmenc_pkg::ANGLE_BITS-1:0]     single_turn,
  output logic signed [pwmenc_pkg::TURN_BITS-1:0] turn_count,
  output logic [pwmenc_pkg::POS_BITS-1:0]       position,
  output logic [pwmenc_pkg::ERROR_BITS-1:0]     error_count
);

  localparam int TB = pwmenc_pkg::TIMER_BITS;
  localparam int PB = pwmenc_pkg::PROD_BITS;
  localparam int CB = pwmenc_pkg::CLK_BITS;
  localparam int AB = pwmenc_pkg::ANGLE_BITS;
  localparam int NB = pwmenc_pkg::TURN_BITS;
  localparam int EB = pwmenc_pkg::ERROR_BITS;

  // Configuration registers
  logic [CB-1:0] cycle_clocks_r, min_valid_r, max_valid_r;
  logic [AB-1:0] wrap_high_r, wrap_low_r;

  // Working registers
  logic [TB-1:0] period_r, high_r;
  logic [TB-1:0] rem_r, rem_nxt;
  logic [PB-1:0] dq_r, dq_nxt;
  logic [pwmenc_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;

  // Decoder state
  logic          valid_r, valid_nxt;
  logic [AB-1:0] angle_r, angle_nxt;
  logic [NB-1:0] turns_r, turns_nxt;
  logic [EB-1:0] bad_r, bad_nxt;

  logic [TB:0]   rem_sh;
  logic          rem_ge;
  logic [AB-1:0] fresh;
  logic [EB-1:0] bad_inc;
  logic          in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_clocks_r <= pwmenc_pkg::RST_CYCLE_CLOCKS;
      min_valid_r    <= pwmenc_pkg::RST_MIN_VALID;
      max_valid_r    <= pwmenc_pkg::RST_MAX_VALID;
      wrap_high_r    <= pwmenc_pkg::RST_WRAP_HIGH;
      wrap_low_r     <= pwmenc_pkg::RST_WRAP_LOW;
    end else if (cfg_we) begin
      case (cfg_index)
        pwmenc_pkg::REG_CYCLE_CLOCKS: cycle_clocks_r <= cfg_data[CB-1:0];
        pwmenc_pkg::REG_MIN_VALID:    min_valid_r    <= cfg_data[CB-1:0];
        pwmenc_pkg::REG_MAX_VALID:    max_valid_r    <= cfg_data[CB-1:0];
        pwmenc_pkg::REG_WRAP_HIGH:    wrap_high_r    <= cfg_data[AB-1:0];
        pwmenc_pkg::REG_WRAP_LOW:     wrap_low_r     <= cfg_data[AB-1:0];
        default: ;
      endcase
    end
  end

  // One restoring division step: shift the next dividend bit into the
  // remainder and subtract the period when it fits.
  assign rem_sh = {rem_r, dq_r[PB-1]};
  assign rem_ge = (rem_sh >= {1'b0, period_r});
  assign sts.div_last = (cnt_r == '0);

  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    cnt_nxt = cnt_r;
    if (cmd.mul) begin
      rem_nxt = '0;
      dq_nxt  = PB'(high_r) * PB'(cycle_clocks_r);
      cnt_nxt = pwmenc_pkg::CNT_BITS'(PB - 1);
    end else if (cmd.step) begin
      rem_nxt = rem_ge ? TB'(rem_sh - {1'b0, period_r}) : rem_sh[TB-1:0];
      dq_nxt  = {dq_r[PB-2:0], rem_ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      period_r <= period_ticks;
      high_r   <= high_ticks;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    cnt_r <= cnt_nxt;
  end

  // After the last step dq_r holds the quotient. A zero period never counts as valid.
  assign in_range = (period_r != '0) && (dq_r >= PB'(min_valid_r)) &&
                    (dq_r <= PB'(max_valid_r));
  assign fresh    = dq_r[AB-1:0] - min_valid_r[AB-1:0];
  assign bad_inc  = bad_r + 1'b1;

  always_comb begin
    valid_nxt = valid_r;
    angle_nxt = angle_r;
    turns_nxt = turns_r;
    bad_nxt   = bad_r;
    if (cmd.update) begin
      valid_nxt = in_range;
      if (in_range) begin
        angle_nxt = fresh;
        bad_nxt   = '0;
        if ((angle_r > wrap_high_r) && (fresh < wrap_low_r)) begin
          turns_nxt = turns_r + 1'b1;
        end else if ((angle_r < wrap_low_r) && (fresh > wrap_high_r)) begin
          turns_nxt = turns_r - 1'b1;
        end
      end else begin
        // The run count skips zero when it wraps.
        bad_nxt = (bad_inc == '0) ? EB'(1) : bad_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      angle_r <= '0;
      turns_r <= '0;
      bad_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      angle_r <= angle_nxt;
      turns_r <= turns_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign reading_valid = valid_r;
  assign single_turn   = angle_r;
  assign turn_count    = turns_r;
  assign position      = pwmenc_pkg::POS_BITS'({turns_r, angle_r});
  assign error_count   = bad_r;

endmodule
